### hw/rtl/fbm_pkg.sv
// Shared types and constants for the fBm value-noise height pipeline.
// Used by fbm_value_noise_height; depends on nothing.
package fbm_pkg;

   // Request and response payloads
   typedef struct packed {
      logic signed [23:0] world_x;
      logic signed [23:0] world_z;
   } req_type;

   typedef struct packed {
      logic [15:0] noise_level;
      logic [10:0] height;
   } rsp_type;

   // Register file index
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SCALE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_HEIGHT = 3'd7;

   // Reset and fallback values
   localparam logic [31:0] DEF_SEED         = 32'd0;
   localparam logic [3:0]  DEF_OCTAVES      = 4'd4;
   localparam logic [15:0] DEF_PERSISTENCE  = 16'd2048;
   localparam logic [15:0] DEF_LACUNARITY   = 16'd8192;
   localparam logic [15:0] DEF_NOISE_SCALE  = 16'd1966;
   localparam logic [9:0]  DEF_BASE_HEIGHT  = 10'd20;
   localparam logic [9:0]  DEF_AMPLITUDE    = 10'd18;
   localparam logic [10:0] DEF_WORLD_HEIGHT = 11'd128;
   localparam logic [15:0] LAC_ONE          = 16'd4096;
   localparam logic [10:0] HEIGHT_MAX       = 11'd1024;

   // Lattice hash constants
   localparam logic [31:0] HASH_X_MUL    = 32'd374761393;
   localparam logic [31:0] HASH_Z_MUL    = 32'd668265263;
   localparam logic [31:0] HASH_MIX_MUL  = 32'd1274126177;
   localparam int          OCT_SEED_STEP = 1013;
   localparam logic [31:0] AMP_START     = 32'd4096;

   // Noise values are Q0.24, quotient of the final divide
   localparam int NOISE_W = 24;

endpackage

### hw/rtl/fbm_value_noise_height.sv
// fBm 2D value-noise terrain height, fully pipelined.
// Depends on fbm_pkg (payload types, register indexes, hash constants).

// Takes one column coordinate per request and returns its noise level and
// clamped terrain height. The block accepts one request every clock cycle
// unless req_stall is high; each request passes through an input stage,
// seven stages per octave, a 24-stage restoring divider that normalizes by
// the total amplitude and two height stages, then the response
// register. A two-entry output buffer lets a new request in
// while a response waits; the request side stalls only when both are full.
// Registers are written through the csr port, which is always ready; they
// must only be changed while no request is in flight.
module fbm_value_noise_height
   import fbm_pkg::*;
#(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
   localparam int TOT_W = 32 + $clog2(MAX_OCTAVES);
   localparam int SUM_W = 56 + $clog2(MAX_OCTAVES);

   // Configuration registers
   logic [31:0] seed_ff;
   logic [3:0]  octaves_ff;
   logic [15:0] persistence_ff;
   logic [15:0] lacunarity_ff;
   logic [15:0] noise_scale_ff;
   logic [9:0]  base_height_ff;
   logic [9:0]  amplitude_ff;
   logic [10:0] world_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= DEF_SEED;
         octaves_ff      <= DEF_OCTAVES;
         persistence_ff  <= DEF_PERSISTENCE;
         lacunarity_ff   <= DEF_LACUNARITY;
         noise_scale_ff  <= DEF_NOISE_SCALE;
         base_height_ff  <= DEF_BASE_HEIGHT;
         amplitude_ff    <= DEF_AMPLITUDE;
         world_height_ff <= DEF_WORLD_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEED:         seed_ff         <= csr_data;
            CSR_OCTAVES:      octaves_ff      <= csr_data[3:0];
            CSR_PERSISTENCE:  persistence_ff  <= csr_data[15:0];
            CSR_LACUNARITY:   lacunarity_ff   <= csr_data[15:0];
            CSR_NOISE_SCALE:  noise_scale_ff  <= csr_data[15:0];
            CSR_BASE_HEIGHT:  base_height_ff  <= csr_data[9:0];
            CSR_AMPLITUDE:    amplitude_ff    <= csr_data[9:0];
            CSR_WORLD_HEIGHT: world_height_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // Effective settings with out-of-range values replaced
   logic [OCT_W-1:0] oct_eff;
   logic [15:0]      pers_eff;
   logic [15:0]      lac_eff;
   logic [15:0]      ns_eff;
   logic [10:0]      top_eff;

   always_comb begin
      if (octaves_ff == 4'd0) begin
         oct_eff = OCT_W'(1);
      end else if (int'(octaves_ff) > MAX_OCTAVES) begin
         oct_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         oct_eff = OCT_W'(octaves_ff);
      end
      pers_eff = (persistence_ff == 16'd0) ? DEF_PERSISTENCE : persistence_ff;
      lac_eff  = (lacunarity_ff > LAC_ONE) ? lacunarity_ff : DEF_LACUNARITY;
      ns_eff   = (noise_scale_ff == 16'd0) ? DEF_NOISE_SCALE : noise_scale_ff;
      if (world_height_ff == 11'd0) begin
         top_eff = 11'd1;
      end else if (world_height_ff > HEIGHT_MAX) begin
         top_eff = HEIGHT_MAX;
      end else begin
         top_eff = world_height_ff;
      end
   end

   // Pipeline advance: everything moves unless the output buffer is full
   logic skid_v_ff;
   logic adv;

   assign adv       = !skid_v_ff;
   assign req_stall = !adv;

   // Input stage: scale to Q32.16 noise space
   logic signed [40:0] in_px;
   logic signed [40:0] in_pz;
   logic               in_v_ff;
   logic [47:0]        in_cx_ff;
   logic [47:0]        in_cz_ff;

   assign in_px = $signed(req_data.world_x) * $signed({1'b0, ns_eff});
   assign in_pz = $signed(req_data.world_z) * $signed({1'b0, ns_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff  <= req_valid;
         in_cx_ff <= {{7{in_px[40]}}, in_px};
         in_cz_ff <= {{7{in_pz[40]}}, in_pz};
      end
   end

   // Boundaries between octave sections
   logic             b_v   [MAX_OCTAVES+1];
   logic [47:0]      b_cx  [MAX_OCTAVES+1];
   logic [47:0]      b_cz  [MAX_OCTAVES+1];
   logic [31:0]      b_amp [MAX_OCTAVES+1];
   logic [SUM_W-1:0] b_sum [MAX_OCTAVES+1];
   logic [TOT_W-1:0] b_tot [MAX_OCTAVES+1];

   assign b_v[0]   = in_v_ff;
   assign b_cx[0]  = in_cx_ff;
   assign b_cz[0]  = in_cz_ff;
   assign b_amp[0] = AMP_START;
   assign b_sum[0] = '0;
   assign b_tot[0] = '0;

   // One seven-stage section per octave
   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      localparam logic [31:0] SEED_OFS = 32'(o * OCT_SEED_STEP);

      logic               act;
      logic [31:0]        sqx;
      logic [31:0]        sqz;
      logic signed [64:0] lpx;
      logic signed [64:0] lpz;
      logic [47:0]        ampp;
      logic [31:0]        oseed;
      logic [31:0]        hx [2];
      logic [31:0]        hz [2];
      logic [31:0]        h  [4];
      logic [33:0]        ex;
      logic [33:0]        ez;
      logic [23:0]        cv [4];
      logic [16:0]        inx;
      logic [16:0]        inz;
      logic [41:0]        lom;
      logic [41:0]        him;
      logic [41:0]        nm;

      // Carried fields
      logic [47:0]      ncx_ff  [1:6];
      logic [47:0]      ncz_ff  [1:6];
      logic [31:0]      namp_ff [1:6];
      logic [31:0]      amp_ff  [1:6];
      logic [SUM_W-1:0] sum_ff  [1:7];
      logic [TOT_W-1:0] tot_ff  [1:6];
      logic             act_ff  [1:6];
      logic             v_ff    [1:7];
      logic [47:0]      ncx7_ff;
      logic [47:0]      ncz7_ff;
      logic [31:0]      namp7_ff;
      logic [TOT_W-1:0] tot7_ff;

      // Stage payloads
      logic [31:0] mx_ff, mz_ff;
      logic [15:0] tx_ff, tz_ff, t2x_ff, t2z_ff;
      logic [31:0] g_ff [4];
      logic [16:0] wx2_ff, wz2_ff, wx3_ff, wz3_ff, wz4_ff;
      logic [31:0] p_ff [4];
      logic [23:0] lo_ff, hi_ff, n_ff;
      logic [55:0] pr_ff;

      assign act   = OCT_W'(o) < oct_eff;
      assign sqx   = b_cx[o][15:0] * b_cx[o][15:0];
      assign sqz   = b_cz[o][15:0] * b_cz[o][15:0];
      assign lpx   = $signed(b_cx[o]) * $signed({1'b0, lac_eff});
      assign lpz   = $signed(b_cz[o]) * $signed({1'b0, lac_eff});
      assign ampp  = b_amp[o] * pers_eff;
      assign oseed = seed_ff + SEED_OFS;

      // Corner hash front half; neighbor x1*C = x0*C + C
      always_comb begin
         hx[0] = mx_ff;
         hx[1] = mx_ff + HASH_X_MUL;
         hz[0] = mz_ff;
         hz[1] = mz_ff + HASH_Z_MUL;
         for (int k = 0; k < 4; k++) begin
            h[k] = oseed ^ hx[k % 2] ^ hz[k / 2];
         end
      end

      // Smoothstep second product
      assign ex = t2x_ff * (18'd196608 - {1'b0, tx_ff, 1'b0});
      assign ez = t2z_ff * (18'd196608 - {1'b0, tz_ff, 1'b0});

      // Corner values and blends
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            cv[k] = p_ff[k][23:0] ^ {8'd0, p_ff[k][31:16]};
         end
      end
      assign inx = 17'h10000 - wx3_ff;
      assign inz = 17'h10000 - wz4_ff;
      assign lom = 42'(cv[0]) * 42'(inx) + 42'(cv[1]) * 42'(wx3_ff);
      assign him = 42'(cv[2]) * 42'(inx) + 42'(cv[3]) * 42'(wx3_ff);
      assign nm  = 42'(lo_ff) * 42'(inz) + 42'(hi_ff) * 42'(wz4_ff);

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int s = 1; s <= 7; s++) begin
               v_ff[s] <= 1'b0;
            end
         end else if (adv) begin
            // S1: hash products, squares, next coordinate and amplitude
            v_ff[1]    <= b_v[o];
            mx_ff      <= b_cx[o][47:16] * HASH_X_MUL;
            mz_ff      <= b_cz[o][47:16] * HASH_Z_MUL;
            tx_ff      <= b_cx[o][15:0];
            tz_ff      <= b_cz[o][15:0];
            t2x_ff     <= sqx[31:16];
            t2z_ff     <= sqz[31:16];
            ncx_ff[1]  <= lpx[59:12];
            ncz_ff[1]  <= lpz[59:12];
            namp_ff[1] <= (|ampp[47:44]) ? 32'hFFFF_FFFF : ampp[43:12];
            amp_ff[1]  <= b_amp[o];
            sum_ff[1]  <= b_sum[o];
            tot_ff[1]  <= act ? b_tot[o] + TOT_W'(b_amp[o]) : b_tot[o];
            act_ff[1]  <= act;

            // S2: hash mixing, smoothstep weights
            for (int k = 0; k < 4; k++) begin
               g_ff[k] <= h[k] ^ (h[k] >> 13);
            end
            wx2_ff <= ex[32:16];
            wz2_ff <= ez[32:16];

            // S3: final hash multiply
            for (int k = 0; k < 4; k++) begin
               p_ff[k] <= g_ff[k] * HASH_MIX_MUL;
            end
            wx3_ff <= wx2_ff;
            wz3_ff <= wz2_ff;

            // S4: blend along x
            lo_ff  <= lom[39:16];
            hi_ff  <= him[39:16];
            wz4_ff <= wz3_ff;

            // S5: blend along z
            n_ff <= nm[39:16];

            // S6: weight by amplitude
            pr_ff <= n_ff * amp_ff[5];

            // Carry the rest down the section
            for (int s = 2; s <= 6; s++) begin
               v_ff[s]    <= v_ff[s-1];
               ncx_ff[s]  <= ncx_ff[s-1];
               ncz_ff[s]  <= ncz_ff[s-1];
               namp_ff[s] <= namp_ff[s-1];
               amp_ff[s]  <= amp_ff[s-1];
               sum_ff[s]  <= sum_ff[s-1];
               tot_ff[s]  <= tot_ff[s-1];
               act_ff[s]  <= act_ff[s-1];
            end

            // S7: accumulate
            v_ff[7]   <= v_ff[6];
            sum_ff[7] <= act_ff[6] ? sum_ff[6] + SUM_W'(pr_ff) : sum_ff[6];
            ncx7_ff   <= ncx_ff[6];
            ncz7_ff   <= ncz_ff[6];
            namp7_ff  <= namp_ff[6];
            tot7_ff   <= tot_ff[6];
         end
      end

      assign b_v[o+1]   = v_ff[7];
      assign b_cx[o+1]  = ncx7_ff;
      assign b_cz[o+1]  = ncz7_ff;
      assign b_amp[o+1] = namp7_ff;
      assign b_sum[o+1] = sum_ff[7];
      assign b_tot[o+1] = tot7_ff;
   end

   // Restoring divider: one quotient bit per stage, sum / total
   logic               dv_v   [NOISE_W+1];
   logic [SUM_W-1:0]   dv_rem [NOISE_W+1];
   logic [TOT_W-1:0]   dv_tot [NOISE_W+1];
   logic [NOISE_W-1:0] dv_q   [NOISE_W+1];

   assign dv_v[0]   = b_v[MAX_OCTAVES];
   assign dv_rem[0] = b_sum[MAX_OCTAVES];
   assign dv_tot[0] = b_tot[MAX_OCTAVES];
   assign dv_q[0]   = '0;

   for (genvar j = 0; j < NOISE_W; j++) begin : g_div
      localparam int B = NOISE_W - 1 - j;

      logic [SUM_W-1:0]   dsh;
      logic               ge;
      logic               v_ff;
      logic [SUM_W-1:0]   rem_ff;
      logic [TOT_W-1:0]   tot_ff;
      logic [NOISE_W-1:0] q_ff;

      assign dsh = SUM_W'(dv_tot[j]) << B;
      assign ge  = dv_rem[j] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff   <= dv_v[j];
            rem_ff <= ge ? dv_rem[j] - dsh : dv_rem[j];
            tot_ff <= dv_tot[j];
            q_ff   <= dv_q[j] | (NOISE_W'(ge) << B);
         end
      end

      assign dv_v[j+1]   = v_ff;
      assign dv_rem[j+1] = rem_ff;
      assign dv_tot[j+1] = tot_ff;
      assign dv_q[j+1]   = q_ff;
   end

   // Height: swing product, then offset and clamp
   logic [15:0]        nl;
   logic [25:0]        hm;
   logic               h1_v_ff;
   logic [15:0]        h1_nl_ff;
   logic [10:0]        h1_m_ff;
   logic signed [12:0] hs;
   logic               fin_v_ff;
   rsp_type            fin_ff;

   assign nl = dv_q[NOISE_W][23:8];
   assign hm = nl * amplitude_ff;
   assign hs = $signed({3'b000, base_height_ff}) + $signed({2'b00, h1_m_ff})
             - $signed({3'b000, amplitude_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_v_ff  <= 1'b0;
         fin_v_ff <= 1'b0;
      end else if (adv) begin
         h1_v_ff  <= dv_v[NOISE_W];
         h1_nl_ff <= nl;
         h1_m_ff  <= hm[25:15];
         fin_v_ff <= h1_v_ff;
         fin_ff.noise_level <= h1_nl_ff;
         if (hs < 13'sd1) begin
            fin_ff.height <= 11'd1;
         end else if (hs > $signed({2'b00, top_eff})) begin
            fin_ff.height <= top_eff;
         end else begin
            fin_ff.height <= hs[10:0];
         end
      end
   end

   // Response register with one-entry skid
   logic    rsp_v_ff;
   rsp_type rsp_ff;
   rsp_type skid_ff;

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || !rsp_stall) begin
         rsp_v_ff  <= skid_v_ff || fin_v_ff;
         rsp_ff    <= skid_v_ff ? skid_ff : fin_ff;
         skid_v_ff <= 1'b0;
      end else if (adv && fin_v_ff) begin
         skid_ff   <= fin_ff;
         skid_v_ff <= 1'b1;
      end
   end

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the fBm value-noise height pipeline.
// Depends on fbm_pkg and fbm_value_noise_height; stands alone otherwise.
module tb_top;
   import fbm_pkg::*;

   localparam int MAXOCT = 8;
   localparam int PIPE_LAT = 1 + 7 * MAXOCT + 24 + 2 + 1;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 1500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   fbm_value_noise_height #(.MAX_OCTAVES(MAXOCT)) DUT (.*);

   always #2 clock = ~clock;

   // Register shadow used by the height predictor
   logic [31:0] r_seed;
   logic [3:0]  r_oct;
   logic [15:0] r_pers, r_lac, r_scale;
   logic [9:0]  r_base, r_amp;
   logic [10:0] r_top;

   rsp_type expected_heights[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet_mode = 1'b0;     // no random idling on either side
   int hold_rsp = 0;          // long receiver hold-off, in cycles

   function automatic logic [23:0] lattice_hash(logic [31:0] s, logic [31:0] x,
                                                logic [31:0] z);
      logic [31:0] h;
      h = s ^ (x * HASH_X_MUL) ^ (z * HASH_Z_MUL);
      h = (h ^ (h >> 13)) * HASH_MIX_MUL;
      h = h ^ (h >> 16);
      return h[23:0];
   endfunction

   function automatic logic [63:0] smooth_weight(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t) >> 16;
      return (t2 * (64'd196608 - 2 * t)) >> 16;
   endfunction

   function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] w);
      return (a * (64'd65536 - w) + b * w) >> 16;
   endfunction

   function automatic rsp_type column_height(req_type q);
      logic [63:0] pers, lac, ns, top, amp, sum, total, nl, wx, wz, lo, hi;
      logic [47:0] cx, cz;
      logic [31:0] s, x0, z0;
      logic signed [63:0] h;
      int oct;
      rsp_type r;
      oct = (r_oct < 1) ? 1 : (r_oct > MAXOCT) ? MAXOCT : r_oct;
      pers = (r_pers != 0) ? r_pers : 64'd2048;
      lac = (r_lac > LAC_ONE) ? r_lac : 64'd8192;
      ns = (r_scale != 0) ? r_scale : 64'd1966;
      top = (r_top < 1) ? 1 : (r_top > HEIGHT_MAX) ? 64'd1024 : r_top;
      cx = 48'($signed(64'(q.world_x)) * $signed(ns));
      cz = 48'($signed(64'(q.world_z)) * $signed(ns));
      amp = 4096; sum = 0; total = 0;
      for (int o = 0; o < oct; o++) begin
         s = r_seed + o * OCT_SEED_STEP;
         x0 = cx[47:16]; z0 = cz[47:16];
         wx = smooth_weight(cx[15:0]);
         wz = smooth_weight(cz[15:0]);
         lo = lerp16(lattice_hash(s, x0, z0), lattice_hash(s, x0 + 1, z0), wx);
         hi = lerp16(lattice_hash(s, x0, z0 + 1), lattice_hash(s, x0 + 1, z0 + 1), wx);
         sum += lerp16(lo, hi, wz) * amp;
         total += amp;
         amp = (amp * pers) >> 12;
         if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
         // 48-bit coordinate is two's complement
         cx = 48'(($signed(64'($signed(cx))) * $signed(lac)) >>> 12);
         cz = 48'(($signed(64'($signed(cz))) * $signed(lac)) >>> 12);
      end
      nl = (sum / total) >> 8;
      h = $signed(64'(r_base)) + $signed((2 * nl * r_amp) >> 16) - $signed(64'(r_amp));
      if (h < 1) h = 1;
      if (h > $signed(top)) h = top;
      r.noise_level = nl[15:0];
      r.height = h[10:0];
      return r;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SEED:         r_seed = val;
         CSR_OCTAVES:      r_oct = val[3:0];
         CSR_PERSISTENCE:  r_pers = val[15:0];
         CSR_LACUNARITY:   r_lac = val[15:0];
         CSR_NOISE_SCALE:  r_scale = val[15:0];
         CSR_BASE_HEIGHT:  r_base = val[9:0];
         CSR_AMPLITUDE:    r_amp = val[9:0];
         default:          r_top = val[10:0];
      endcase
   endtask

   task automatic wait_drained();
      while (expected_heights.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   // Send one request; optionally record a typed-in expectation
   task automatic send_column(logic [23:0] x, logic [23:0] z, bit fixed,
                              rsp_type want);
      req_type q;
      while (!quiet_mode && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      q.world_x = x; q.world_z = z;
      req_valid <= 1'b1; req_data <= q;
      do @(posedge clock); while (req_stall);
      expected_heights.push_back(fixed ? want : column_height(q));
      @(negedge clock);
   endtask

   task automatic random_regs(bit extreme);
      csr_write(CSR_SEED, extreme ? 32'hFFFF_FFFF : $urandom);
      csr_write(CSR_OCTAVES, $urandom_range(15));
      csr_write(CSR_PERSISTENCE, extreme ? 16'hFFFF : $urandom_range(6000));
      csr_write(CSR_LACUNARITY, extreme ? 16'hFFFF : $urandom_range(12000));
      csr_write(CSR_NOISE_SCALE, extreme ? 16'hFFFF : $urandom_range(65535));
      csr_write(CSR_BASE_HEIGHT, extreme ? 10'h3FF : $urandom_range(1023));
      csr_write(CSR_AMPLITUDE, extreme ? 10'h3FF : $urandom_range(1023));
      csr_write(CSR_WORLD_HEIGHT, extreme ? 11'h7FF : $urandom_range(2047));
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'(24'h800000 + $urandom_range(3));
         1: return 24'(24'h7FFFFF - $urandom_range(3));
         2: return 24'($signed($urandom_range(2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_rsp > 0) begin
         rsp_stall <= 1'b1;
         hold_rsp <= hold_rsp - 1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(99) < 7);
      end
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_heights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type w;
            w = expected_heights.pop_front();
            if (w.noise_level !== rsp_data.noise_level || w.height !== rsp_data.height) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected noise %0d height %0d, got noise %0d height %0d",
                           w.noise_level, w.height, rsp_data.noise_level, rsp_data.height);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Directed rows: coordinates; a typed-in result where it is obvious
   typedef struct {
      logic [23:0] x, z;
      bit fixed;
      rsp_type want;
   } column_row;

   initial begin
      column_row rows[$];
      rsp_type one;
      r_seed = DEF_SEED; r_oct = DEF_OCTAVES; r_pers = DEF_PERSISTENCE;
      r_lac = DEF_LACUNARITY; r_scale = DEF_NOISE_SCALE; r_base = DEF_BASE_HEIGHT;
      r_amp = DEF_AMPLITUDE; r_top = DEF_WORLD_HEIGHT;
      one = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Origin, extremes and mixed signs under the reset registers
      rows.push_back('{24'h000000, 24'h000000, 1'b0, one});
      rows.push_back('{24'h7FFFFF, 24'h7FFFFF, 1'b0, one});
      rows.push_back('{24'h800000, 24'h800000, 1'b0, one});
      rows.push_back('{24'h800000, 24'h7FFFFF, 1'b0, one});
      rows.push_back('{24'hFFFFFF, 24'h000001, 1'b0, one});
      rows.push_back('{24'h555555, 24'hAAAAAA, 1'b0, one});
      foreach (rows[i]) send_column(rows[i].x, rows[i].z, rows[i].fixed, rows[i].want);
      req_valid <= 1'b0;
      wait_drained();

      // Zero and out-of-range registers take their fallbacks; height clamps
      csr_write(CSR_OCTAVES, 0);
      csr_write(CSR_PERSISTENCE, 0);
      csr_write(CSR_LACUNARITY, 4096);
      csr_write(CSR_NOISE_SCALE, 0);
      csr_write(CSR_AMPLITUDE, 1023);
      csr_write(CSR_BASE_HEIGHT, 0);
      csr_write(CSR_WORLD_HEIGHT, 0);
      // One octave at the origin with seed 0: corner hash is zero
      one.noise_level = 16'd0; one.height = 11'd1;
      send_column(24'h000000, 24'h000000, 1'b1, one);
      for (int i = 0; i < 6; i++) send_column(rand_coord(), rand_coord(), 1'b0, one);
      req_valid <= 1'b0;
      wait_drained();
      random_regs(1'b1);
      for (int i = 0; i < 8; i++) send_column(rand_coord(), rand_coord(), 1'b0, one);
      req_valid <= 1'b0;
      wait_drained();

      // Random phases, each under fresh registers
      for (int ph = 0; ph < 6; ph++) begin
         random_regs(1'b0);
         quiet_mode = (ph == 2);
         if (ph == 3) hold_rsp = 3 * PIPE_LAT;
         for (int i = 0; i < N_RANDOM / 6; i++)
            send_column(rand_coord(), rand_coord(), 1'b0, one);
         req_valid <= 1'b0;
         wait_drained();
      end
      quiet_mode = 1'b0;

      if (mismatches == 0 && expected_heights.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

### filelist.f
hw/rtl/fbm_pkg.sv
hw/rtl/fbm_value_noise_height.sv
tb/sv/tb_top.sv
